// ===== rtl/heightmap_column_face_emitter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heightmap column face emitter
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_COLUMN_FACE_EMITTER_ASSERT_SVH
`define HEIGHTMAP_COLUMN_FACE_EMITTER_ASSERT_SVH

// Condition must never be true at a clock edge.
`define HCE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define HCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hce_pkg.sv =====
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types and constants of the heightmap column face emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package hce_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_DEPTH   = 256;
    localparam int DEF_HEIGHT_BITS = 15;

    localparam int COORD_BITS     = 8;
    localparam int IN_HEIGHT_BITS = 16;
    localparam int VALUE_BITS     = 15;   // clamped write value, and y fields
    localparam int GRID_BITS      = 9;
    localparam int ORIGIN_BITS    = 9;
    localparam int COUNT_BITS     = 32;
    localparam int KIND_BITS      = 3;
    localparam int NUM_FACES      = 5;
    localparam int NUM_NBRS       = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [COUNT_BITS-1:0] VERTEX_STEP     = 32'd4;
    localparam logic [COUNT_BITS-1:0] TRI_INDEX_STEP  = 32'd6;
    localparam logic [COUNT_BITS-1:0] LINE_INDEX_STEP = 32'd8;

    // Request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_CELL    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [1:0] CFG_GRID_DEPTH = 2'd1;
    localparam logic [1:0] CFG_LINE_MODE  = 2'd2;

    localparam logic [GRID_BITS-1:0] GRID_WIDTH_RESET = 9'd256;
    localparam logic [GRID_BITS-1:0] GRID_DEPTH_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_CELL    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef struct packed {
        logic [GRID_BITS-1:0] grid_width;
        logic [GRID_BITS-1:0] grid_depth;
        logic                 line_mode;
    } cfg_t;

    // Neighbour flags, lowest bit up: +x, -x, +z, -z inside the grid.
    typedef struct packed {
        op_t                    op;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  z;
        logic [VALUE_BITS-1:0]  value;
        logic [NUM_NBRS-1:0]    nbr_ok;
        logic [ORIGIN_BITS-1:0] ox;
        logic [ORIGIN_BITS-1:0] oz;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [ORIGIN_BITS-1:0] ox;
        logic [ORIGIN_BITS-1:0] oz;
        logic [VALUE_BITS-1:0]  y_low;
        logic [VALUE_BITS-1:0]  y_high;
        logic [COUNT_BITS-1:0]  first_vertex;
        logic [COUNT_BITS-1:0]  first_index;
        logic                   last;
    } face_t;

endpackage

`default_nettype wire

// ===== rtl/heightmap_column_face_emitter.sv =====
// ----------------------------------------------------------------------------
// heightmap_column_face_emitter
// Heightmap store that turns cell requests into top and side face records.
// ----------------------------------------------------------------------------
// The front end accepts one request per cycle while its two-entry command
// queue has room; requests that produce nothing (cells outside the grid in
// use, writes outside the store, unknown codes) are dropped there at once.
// The back end works one command at a time: a height write or a counter
// restart is done as it is popped, a cell request emits n faces (1 to 5)
// and a zero-height cell emits nothing. The order of work is set by the
// single read port of the height store and its registered read: the idle
// state pops the command, the read state reads the cell and its four
// neighbours one after another before the first face leaves, and the face
// output register then sends one face per cycle while m_tready is not
// holding it back. The height store has no clearing pass; cells must be
// written before they are read.
// Configuration writes are taken at any cycle and must only be made while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heightmap_column_face_emitter_assert.svh"

module heightmap_column_face_emitter import hce_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,

    // Configuration write port
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [8:0]     cfg_wdata,

    // Request stream
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,   // cell_x[7:0], cell_z[15:8], height[31:16]
    input  logic [1:0]     s_tuser,   // req_type[1:0]

    // Face stream
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [111:0]   m_tdata,   // origin_x_half[8:0], origin_z_half[17:9],
                                      // y_low[32:18], y_high[47:33],
                                      // first_vertex[79:48], first_index[111:80]
    output logic [2:0]     m_tuser,   // face_kind[2:0]
    output logic           m_tlast    // last_face
);

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    cmd_t    push_cmd;
    cmd_t    pop_cmd;
    logic    q_push;
    logic    q_pop;
    face_t   face;

    // Hold the configuration; drop writes to indexes beyond the list.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH: cfg_next.grid_width = cfg_wdata;
                CFG_GRID_DEPTH: cfg_next.grid_depth = cfg_wdata;
                CFG_LINE_MODE:  cfg_next.line_mode  = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_width <= GRID_WIDTH_RESET;
            cfg_reg.grid_depth <= GRID_DEPTH_RESET;
            cfg_reg.line_mode  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify each request and push the ones that carry work.
    hce_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_DEPTH   (MAX_DEPTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .cfg      (cfg_reg),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .req_type (s_tuser),
        .cell_x   (s_tdata[7:0]),
        .cell_z   (s_tdata[15:8]),
        .height   (s_tdata[31:16]),
        .q_stat   (q_stat),
        .push     (q_push),
        .cmd      (push_cmd)
    );

    // Decouple request intake from the read and emit sequence.
    hce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    // Execute writes, restarts and cell requests in order.
    hce_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_DEPTH   (MAX_DEPTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .line_mode (cfg_reg.line_mode),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_face    (face)
    );

    // Pack the face record onto the output stream.
    assign m_tdata = {face.first_index, face.first_vertex, face.y_high, face.y_low,
                      face.oz, face.ox};
    assign m_tuser = face.kind;
    assign m_tlast = face.last;

    `HCE_ASSERT_NEVER(a_no_push_when_full, q_push && q_stat.full, "push into full queue")
    `HCE_ASSERT_NEVER(a_no_pop_when_empty, q_pop && q_stat.empty, "pop from empty queue")
    `HCE_ASSERT_NEXT(a_faces_back_to_back, m_tvalid && m_tready && !m_tlast, m_tvalid, "face gap")

endmodule

`default_nettype wire

// ===== rtl/hce_front.sv =====
// ----------------------------------------------------------------------------
// hce_front
// Accepts requests, clamps write heights, range-checks cells and drops
// requests that cause no work.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_front import hce_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  cfg_t                             cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       req_type,
    input  logic [COORD_BITS-1:0]            cell_x,
    input  logic [COORD_BITS-1:0]            cell_z,
    input  logic signed [IN_HEIGHT_BITS-1:0] height,
    input  q_stat_t                          q_stat,
    output logic                             push,
    output cmd_t                             cmd
);

    localparam logic [31:0] HMAX = 32'((64'd1 << HEIGHT_BITS) - 64'd1);

    function automatic logic [GRID_BITS-1:0] clamp_size(input logic [GRID_BITS-1:0] v,
                                                        input int maxv);
        logic [GRID_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = GRID_BITS'(1);
        end else if (int'(v) > maxv) begin
            r = GRID_BITS'(maxv);
        end
        return r;
    endfunction

    logic [GRID_BITS-1:0]  w_use;
    logic [GRID_BITS-1:0]  d_use;
    logic [GRID_BITS-1:0]  xp;
    logic [GRID_BITS-1:0]  zp;
    logic [VALUE_BITS-1:0] v15;
    logic [VALUE_BITS-1:0] hval;
    logic                  keep;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready && keep;

    always_comb begin
        w_use = clamp_size(cfg.grid_width, MAX_WIDTH);
        d_use = clamp_size(cfg.grid_depth, MAX_DEPTH);
        xp    = {1'b0, cell_x} + GRID_BITS'(1);
        zp    = {1'b0, cell_z} + GRID_BITS'(1);

        // Negative heights store as zero, large ones saturate.
        v15  = height[IN_HEIGHT_BITS-1] ? '0 : height[VALUE_BITS-1:0];
        hval = v15;
        if ({17'd0, v15} > HMAX) begin
            hval = VALUE_BITS'(HMAX);
        end

        cmd.op     = OP_WRITE;
        cmd.x      = cell_x;
        cmd.z      = cell_z;
        cmd.value  = hval;
        cmd.nbr_ok = {cell_z != '0, zp < d_use, cell_x != '0, xp < w_use};
        cmd.ox     = {cell_x, 1'b0} - w_use;
        cmd.oz     = {cell_z, 1'b0} - d_use;

        keep = 1'b0;
        unique case (req_type)
            REQ_WRITE: begin
                cmd.op = OP_WRITE;
                keep   = (int'(cell_x) < MAX_WIDTH) && (int'(cell_z) < MAX_DEPTH);
            end
            REQ_CELL: begin
                cmd.op = OP_CELL;
                keep   = ({1'b0, cell_x} < w_use) && ({1'b0, cell_z} < d_use);
            end
            REQ_RESTART: begin
                cmd.op = OP_RESTART;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/hce_queue.sv =====
// ----------------------------------------------------------------------------
// hce_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_queue import hce_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    pop_cmd,
    output q_stat_t stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          ent_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign stat.full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_cmd    = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hce_back.sv =====
// ----------------------------------------------------------------------------
// hce_back
// Height store, neighbour read sequencer, face emitter and mesh counters.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_back import hce_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_stat_t q_stat,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    input  logic    line_mode,
    output logic    m_valid,
    input  logic    m_ready,
    output face_t   m_face
);

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int ZB    = $clog2(MAX_DEPTH);
    localparam int AW    = XB + ZB;
    localparam int DEPTH = 1 << AW;
    localparam int HB    = HEIGHT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [GRID_BITS-1:0] xc,
                                                input logic [GRID_BITS-1:0] zc);
        return {ZB'(zc), XB'(xc)};
    endfunction

    logic [HB-1:0] mem [DEPTH];
    logic [HB-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [HB-1:0] mem_wdata;
    logic [AW-1:0] rd_addr;

    state_t                 state_reg, state_next;
    logic [2:0]             step_reg, step_next;
    logic [COORD_BITS-1:0]  x_reg, x_next;
    logic [COORD_BITS-1:0]  z_reg, z_next;
    logic [NUM_NBRS-1:0]    ok_reg, ok_next;
    logic [ORIGIN_BITS-1:0] ox_reg, ox_next;
    logic [ORIGIN_BITS-1:0] oz_reg, oz_next;
    logic [HB-1:0]          ylo_reg [NUM_FACES];
    logic [HB-1:0]          ylo_next [NUM_FACES];
    logic [NUM_FACES-1:0]   mask_reg, mask_next;
    logic [COUNT_BITS-1:0]  vcnt_reg, vcnt_next;
    logic [COUNT_BITS-1:0]  icnt_reg, icnt_next;
    logic                   mvalid_reg, mvalid_next;
    face_t                  face_reg, face_next;

    logic [2:0]           cap_idx;
    logic [HB-1:0]        cap_data;
    logic                 cap_lt;
    logic [2:0]           sel_idx;
    logic [NUM_FACES-1:0] sel_bit;
    logic [NUM_FACES-1:0] rest;
    logic                 slot_free;
    logic [GRID_BITS-1:0] rx, rz;

    assign m_valid   = mvalid_reg;
    assign m_face    = face_reg;
    assign slot_free = !mvalid_reg || m_ready;

    // Read address: the popped cell in idle, then +x, -x, +z, -z.
    always_comb begin
        rx = {1'b0, q_cmd.x};
        rz = {1'b0, q_cmd.z};
        if (state_reg == ST_READ) begin
            rx = {1'b0, x_reg};
            rz = {1'b0, z_reg};
            unique case (step_reg)
                3'd1:    rx = {1'b0, x_reg} + GRID_BITS'(1);
                3'd2:    rx = {1'b0, x_reg} - GRID_BITS'(1);
                3'd3:    rz = {1'b0, z_reg} + GRID_BITS'(1);
                3'd4:    rz = {1'b0, z_reg} - GRID_BITS'(1);
                default: ;
            endcase
        end
        rd_addr = cell_addr(rx, rz);
    end

    // Capture of the data returned for the previous read.
    always_comb begin
        cap_idx  = step_reg - 3'd1;
        cap_data = rd_data_reg;
        cap_lt   = rd_data_reg != '0;
        if (step_reg != 3'd1) begin
            cap_data = ok_reg[2'(step_reg - 3'd2)] ? rd_data_reg : '0;
            cap_lt   = cap_data < ylo_reg[0];
        end
    end

    // Lowest pending face goes out first.
    always_comb begin
        sel_idx = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_idx = 3'(i);
            end
        end
        sel_bit = NUM_FACES'(1) << sel_idx;
        rest    = mask_reg & ~sel_bit;
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        z_next      = z_reg;
        ok_next     = ok_reg;
        ox_next     = ox_reg;
        oz_next     = oz_reg;
        ylo_next    = ylo_reg;
        mask_next   = mask_reg;
        vcnt_next   = vcnt_reg;
        icnt_next   = icnt_reg;
        mvalid_next = mvalid_reg && !m_ready;
        face_next   = face_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cell_addr({1'b0, q_cmd.x}, {1'b0, q_cmd.z});
        mem_wdata   = HB'(q_cmd.value);

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_WRITE: begin
                            mem_we = 1'b1;
                        end
                        OP_RESTART: begin
                            vcnt_next = '0;
                            icnt_next = '0;
                        end
                        OP_CELL: begin
                            x_next     = q_cmd.x;
                            z_next     = q_cmd.z;
                            ok_next    = q_cmd.nbr_ok;
                            ox_next    = q_cmd.ox;
                            oz_next    = q_cmd.oz;
                            mask_next  = '0;
                            step_next  = 3'd1;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                ylo_next[cap_idx]  = cap_data;
                mask_next[cap_idx] = cap_lt;
                if (step_reg == 3'(NUM_FACES)) begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_EMIT: begin
                if (mask_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    face_next.kind         = sel_idx;
                    face_next.ox           = ox_reg;
                    face_next.oz           = oz_reg;
                    face_next.y_low        = VALUE_BITS'(ylo_reg[sel_idx]);
                    face_next.y_high       = VALUE_BITS'(ylo_reg[0]);
                    face_next.first_vertex = vcnt_reg;
                    face_next.first_index  = icnt_reg;
                    face_next.last         = (rest == '0);
                    mvalid_next            = 1'b1;
                    mask_next              = rest;
                    vcnt_next              = vcnt_reg + VERTEX_STEP;
                    icnt_next              = icnt_reg +
                                             (line_mode ? LINE_INDEX_STEP : TRI_INDEX_STEP);
                    if (rest == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            mask_reg   <= '0;
            vcnt_reg   <= '0;
            icnt_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mask_reg   <= mask_next;
            vcnt_reg   <= vcnt_next;
            icnt_reg   <= icnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        z_reg    <= z_next;
        ok_reg   <= ok_next;
        ox_reg   <= ox_next;
        oz_reg   <= oz_next;
        ylo_reg  <= ylo_next;
        face_reg <= face_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire
